// File: rtl/ddo_pkg.sv
// Shared types, constants and the arctangent table for the odometry core.
// No dependencies.
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POS_FRAC_BITS_DEF = 8;
  localparam int ATAN_LEN          = 24;

  localparam logic [15:0] MM_PER_PULSE_RST   = 16'd8579;
  localparam logic [23:0] INV_WHEEL_BASE_RST = 24'd138655;
  localparam logic [29:0] TURN_PER_RAD       = 30'd683565276;
  localparam logic [33:0] CORDIC_GAIN        = 34'd652032874;

  localparam int MUL_W = 66;
  localparam int OPB_W = 34;

  localparam logic [7:0] REG_MM_PER_PULSE   = 8'd0;
  localparam logic [7:0] REG_INV_WHEEL_BASE = 8'd1;

  typedef struct packed {
    logic       start;
    logic       b_signed;
    logic [5:0] nbits;
  } mul_req_t;

  function automatic logic [31:0] atan_at(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ddo_mul.sv
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
// Depends on ddo_pkg (mul_req_t, widths).
module ddo_mul
  import ddo_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mul_req_t                req,
  input  logic signed [MUL_W-1:0] a,
  input  logic [OPB_W-1:0]        b,
  output logic signed [MUL_W-1:0] prod,
  output logic                    busy,
  output logic                    done
);

  logic signed [MUL_W-1:0] acc;
  logic signed [MUL_W-1:0] a_sh;
  logic [OPB_W-1:0]        b_sh;
  logic [5:0]              cnt;
  logic                    bsg;
  logic                    last;

  assign last = (cnt == 6'd1);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      acc  <= '0;
      a_sh <= a;
      b_sh <= b;
      cnt  <= req.nbits;
      bsg  <= req.b_signed;
    end else if (busy) begin
      // sign bit of a signed multiplier carries negative weight
      if (b_sh[0]) begin
        acc <= (last && bsg) ? acc - a_sh : acc + a_sh;
      end
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
      cnt  <= cnt - 6'd1;
      if (last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// File: rtl/ddo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle, cos/sin in Q30.
// Depends on ddo_pkg (atan_at, CORDIC_GAIN).
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic signed [33:0] cos_q,
  output logic signed [33:0] sin_q,
  output logic               busy,
  output logic               done
);

  localparam int NSTEP = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
  localparam logic [4:0] LAST_I = 5'(NSTEP - 1);

  logic signed [33:0] x, y, z;
  logic signed [33:0] xs, ys;
  logic [4:0]         i;
  logic               flip;
  logic               quad_flip;
  logic [31:0]        a2;

  assign quad_flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
  assign a2        = quad_flip ? (angle ^ 32'h8000_0000) : angle;
  assign xs        = x >>> i;
  assign ys        = y >>> i;
  assign cos_q     = flip ? -x : x;
  assign sin_q     = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      flip <= quad_flip;
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= 34'(signed'(a2));
      i    <= '0;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - 34'(atan_at(i));
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + 34'(atan_at(i));
      end
      i <= i + 5'd1;
      if (i == LAST_I) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// File: rtl/diff_drive_odometry_core.sv
// Differential-drive odometry core: encoder deltas in, saturating pose out.
// Each item takes six passes of the bit-serial multiplier (16, 16, 24, 30, 34 and 34
// bits) with the serial CORDIC between the fourth and fifth; a new item is accepted
// only once the previous pose update is done (in_stall is high outside idle).
// Synchronous reset clears pose to zero and restores register defaults.
// Depends on ddo_pkg, ddo_mul, ddo_cordic.
module diff_drive_odometry_core
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] left_delta,
  input  logic signed [15:0] right_delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int SH = 47 - POS_FRAC_BITS;
  localparam logic signed [MUL_W-1:0] RND = MUL_W'(1) <<< (SH - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_DIF  = 4'd2;
  localparam logic [3:0] S_RAD  = 4'd3;
  localparam logic [3:0] S_TRN  = 4'd4;
  localparam logic [3:0] S_COR  = 4'd5;
  localparam logic [3:0] S_MX   = 4'd6;
  localparam logic [3:0] S_MY   = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;

  logic [3:0]              state;
  logic [15:0]             mm_per_pulse;
  logic [23:0]             inv_wheel_base;
  logic signed [31:0]      x_acc, y_acc;
  logic [15:0]             heading_acc;
  logic signed [15:0]      l_q, r_q;
  logic signed [33:0]      sum_mm;
  logic [15:0]             step;
  logic [31:0]             mid;
  logic signed [31:0]      x_new, y_new;

  mul_req_t                mreq;
  logic signed [MUL_W-1:0] op_a;
  logic [OPB_W-1:0]        op_b;
  logic signed [MUL_W-1:0] prod;
  logic                    mul_busy, mul_done;
  logic                    cor_start, cor_busy, cor_done;
  logic signed [33:0]      cos_q, sin_q;

  logic [56:0]             t_step, t_mid;
  logic signed [MUL_W-1:0] d_scaled;
  logic signed [16:0]      lr_sum, lr_dif;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [MUL_W-1:0] d);
    logic signed [MUL_W:0] s;
    s = (MUL_W+1)'(acc) + (MUL_W+1)'(d);
    if (s > (MUL_W+1)'(32'sh7fff_ffff)) begin
      return 32'sh7fff_ffff;
    end else if (s < -(MUL_W+1)'(33'sh0_8000_0000)) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  ddo_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (op_a),
    .b    (op_b),
    .prod (prod),
    .busy (mul_busy),
    .done (mul_done)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (mid),
    .cos_q (cos_q),
    .sin_q (sin_q),
    .busy  (cor_busy),
    .done  (cor_done)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign pos_x     = x_acc;
  assign pos_y     = y_acc;
  assign heading   = heading_acc;

  assign lr_sum   = 17'(left_delta) + 17'(right_delta);
  assign lr_dif   = 17'(r_q) - 17'(l_q);
  assign t_step   = prod[56:0] + (57'd1 << 39);
  assign t_mid    = prod[56:0] + (57'd1 << 24);
  assign d_scaled = (prod + RND) >>> SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mm_per_pulse   <= MM_PER_PULSE_RST;
      inv_wheel_base <= INV_WHEEL_BASE_RST;
      x_acc          <= '0;
      y_acc          <= '0;
      heading_acc    <= '0;
      out_valid      <= 1'b0;
      mreq           <= '0;
      cor_start      <= 1'b0;
    end else begin
      mreq.start <= 1'b0;
      cor_start  <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == REG_MM_PER_PULSE) begin
          mm_per_pulse <= cfg_data[15:0];
        end else if (cfg_index == REG_INV_WHEEL_BASE) begin
          inv_wheel_base <= cfg_data[23:0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            l_q   <= left_delta;
            r_q   <= right_delta;
            op_a  <= MUL_W'(lr_sum);
            op_b  <= OPB_W'(mm_per_pulse);
            mreq  <= '{start: 1'b1, b_signed: 1'b0, nbits: 6'd16};
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (mul_done) begin
            sum_mm <= prod[33:0];
            op_a   <= MUL_W'(lr_dif);
            mreq   <= '{start: 1'b1, b_signed: 1'b0, nbits: 6'd16};
            state  <= S_DIF;
          end
        end
        S_DIF: begin
          if (mul_done) begin
            op_a  <= MUL_W'(signed'(prod[33:0]));
            op_b  <= OPB_W'(inv_wheel_base);
            mreq  <= '{start: 1'b1, b_signed: 1'b0, nbits: 6'd24};
            state <= S_RAD;
          end
        end
        S_RAD: begin
          if (mul_done) begin
            op_a  <= MUL_W'(signed'(prod[57:16]));
            op_b  <= OPB_W'(TURN_PER_RAD);
            mreq  <= '{start: 1'b1, b_signed: 1'b0, nbits: 6'd30};
            state <= S_TRN;
          end
        end
        S_TRN: begin
          if (mul_done) begin
            step      <= t_step[55:40];
            mid       <= {heading_acc, 16'd0} + t_mid[56:25];
            cor_start <= 1'b1;
            state     <= S_COR;
          end
        end
        S_COR: begin
          if (cor_done) begin
            op_a  <= MUL_W'(sum_mm);
            op_b  <= cos_q;
            mreq  <= '{start: 1'b1, b_signed: 1'b1, nbits: 6'(OPB_W)};
            state <= S_MX;
          end
        end
        S_MX: begin
          if (mul_done) begin
            x_new <= sat_add(x_acc, d_scaled);
            op_b  <= sin_q;
            mreq  <= '{start: 1'b1, b_signed: 1'b1, nbits: 6'(OPB_W)};
            state <= S_MY;
          end
        end
        S_MY: begin
          if (mul_done) begin
            y_new <= sat_add(y_acc, d_scaled);
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (!out_valid || !out_stall) begin
            x_acc       <= x_new;
            y_acc       <= y_new;
            heading_acc <= heading_acc + step;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SUM && mreq.start))
    else $error("accepted item did not start the multiplier");
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mul_busy && !cor_busy))
    else $error("arithmetic unit busy while idle");
  a_cor_state: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == S_COR))
    else $error("cordic finished outside its state");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(x_acc) && $stable(heading_acc))
    else $error("pose changed while result stalled");
`endif

endmodule

// File: sim/odometry_checker.sv
// Checker for the odometry core: watches the input, output and register channels,
// predicts the pose for each accepted item and compares field by field.
// Depends on ddo_pkg.
`timescale 1ns / 100ps
module odometry_checker
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] left_delta,
  input  logic signed [15:0] right_delta,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [15:0]        heading,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hdg;
  } pose_t;

  localparam longint TURN_RAD = 64'd683565276;
  localparam longint GAIN = 64'd652032874;

  pose_t pose_q[$];
  logic [15:0] scale_mm;
  logic [23:0] inv_base;
  logic signed [31:0] x_st, y_st;
  logic [15:0] hdg_st;

  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    longint xv, yv, zv, xs, ys;
    logic flip;
    int n;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang[31] = ~ang[31];
    xv = GAIN;
    yv = 0;
    zv = longint'(signed'(ang));
    n = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    for (int i = 0; i < n; i++) begin
      xs = asr(xv, i);
      ys = asr(yv, i);
      if (zv >= 0) begin
        xv -= ys; yv += xs; zv -= longint'(atan_at(i[4:0]));
      end else begin
        xv += ys; yv -= xs; zv += longint'(atan_at(i[4:0]));
      end
    end
    c = flip ? -xv : xv;
    s = flip ? -yv : yv;
  endtask

  task automatic advance_pose(input logic signed [15:0] l, input logic signed [15:0] r);
    longint dl, dr, sum, rad, c, s, dx, dy;
    logic [63:0] t;
    logic [15:0] stp;
    logic [31:0] mid;
    int sh;
    pose_t p;
    dl = longint'(l) * longint'({1'b0, scale_mm});
    dr = longint'(r) * longint'({1'b0, scale_mm});
    sum = dl + dr;
    rad = asr((dr - dl) * longint'({1'b0, inv_base}), 16);
    t = rad * TURN_RAD;
    stp = 16'((t + (64'd1 << 39)) >> 40);
    mid = {hdg_st, 16'd0} + 32'((t + (64'd1 << 24)) >> 25);
    rotate(mid, c, s);
    sh = 47 - POS_FRAC_BITS;
    dx = asr(sum * c + (64'sd1 <<< (sh - 1)), sh);
    dy = asr(sum * s + (64'sd1 <<< (sh - 1)), sh);
    x_st = 32'(clamp32(longint'(x_st) + dx));
    y_st = 32'(clamp32(longint'(y_st) + dy));
    hdg_st = hdg_st + stp;
    p.x = x_st; p.y = y_st; p.hdg = hdg_st;
    pose_q.push_back(p);
  endtask

  assign pending = pose_q.size();

  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      scale_mm <= MM_PER_PULSE_RST;
      inv_base <= INV_WHEEL_BASE_RST;
      x_st = 0; y_st = 0; hdg_st = 0;
      pose_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MM_PER_PULSE) scale_mm <= cfg_data[15:0];
        else if (cfg_index == REG_INV_WHEEL_BASE) inv_base <= cfg_data[23:0];
      end
      if (in_valid && !in_stall) advance_pose(left_delta, right_delta);
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected item x=%0d y=%0d h=%0d", $time, pos_x, pos_y, heading);
          errors <= errors + 1;
        end else begin
          e = pose_q.pop_front();
          if (e.x !== pos_x || e.y !== pos_y || e.hdg !== heading) begin
            $display("%0t: mismatch expected x=%0d y=%0d h=%0d actual x=%0d y=%0d h=%0d",
                     $time, e.x, e.y, e.hdg, pos_x, pos_y, heading);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: sim/tb_diff_drive_odometry_core.sv
// Testbench top for the odometry core: clock, reset, register writes and
// directed plus random encoder deltas with random idling. Depends on ddo_pkg,
// diff_drive_odometry_core and odometry_checker.
`timescale 1ns / 100ps
module tb_diff_drive_odometry_core;
  import ddo_pkg::*;

  localparam int LATENCY = 200;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 1;
  logic signed [15:0] left_delta = 0, right_delta = 0;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0] heading;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int errors, pending, idle_cycles;
  logic stim_done = 0, hold_off = 0;

  always #5 clk = ~clk;

  diff_drive_odometry_core dut (.*);
  odometry_checker chk (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      w = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 0;
      @(negedge clk);
      while (!(out_valid && !out_stall)) @(negedge clk);
    end
  end

  task automatic send_item(input logic [15:0] l, input logic [15:0] r, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 10) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1;
    left_delta <= l;
    right_delta <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] d);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(input int n);
    logic [15:0] l, r;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      l = 16'($urandom);
      if (k < 4) r = l + 16'($urandom_range(0, 64)) - 16'd32;
      else if (k < 6) r = -l;
      else if (k < 8) begin
        l = 16'($urandom_range(0, 200)) - 16'd100;
        r = 16'($urandom_range(0, 200)) - 16'd100;
      end else r = 16'($urandom);
      send_item(l, r, $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    logic [15:0] ext[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    foreach (ext[i]) send_item(ext[i], ext[(i + 2) % 6], 1);
    for (int i = 0; i < 8; i++) send_item(16'h7fff, 16'h7fff, 0);  // full-scale equal forward deltas
    for (int i = 0; i < 6; i++) send_item(16'h8000, 16'h7fff, 1);  // heading wrap
    send_item(16'h8000, 16'h8000, 0);
    write_reg(REG_MM_PER_PULSE, 32'hffff_ffff);
    write_reg(REG_INV_WHEEL_BASE, 32'hffff_ffff);
    write_reg(8'd2, 32'h0000_0001);
    send_item(16'h7fff, 16'h8000, 1);
    send_item(16'h1234, 16'hedcb, 1);
    hold_off = 1;
    random_phase(350);
    write_reg(REG_MM_PER_PULSE, 32'd0);
    write_reg(REG_INV_WHEEL_BASE, 32'd0);
    random_phase(200);
    write_reg(REG_MM_PER_PULSE, 32'h5a5a_0001);
    write_reg(REG_INV_WHEEL_BASE, 32'ha5ff_0000);
    random_phase(300);
    write_reg(REG_MM_PER_PULSE, 32'(MM_PER_PULSE_RST));
    write_reg(REG_INV_WHEEL_BASE, 32'(INV_WHEEL_BASE_RST));
    random_phase(580);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
